// ===== rtl/spq_pkg.sv =====
// Package for the sorted priority queue: sizes, status and action codes,
// and the command and status structs between controller and datapath.
// No dependencies.
package spq_pkg;

  localparam int CAPACITY     = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int PRIO_BITS    = 8;
  localparam int CNT_BITS     = $clog2(CAPACITY + 1);
  localparam int STATUS_BITS  = 2;

  // Output word is payload, priority and occupancy, padded to whole bytes.
  localparam int OUT_USED_BITS = PAYLOAD_BITS + PRIO_BITS + CNT_BITS;
  localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;
  localparam int IN_USED_BITS  = PAYLOAD_BITS + PRIO_BITS;
  localparam int IN_DATA_BITS  = ((IN_USED_BITS + 7) / 8) * 8;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  localparam logic [STATUS_BITS-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic                   load;    // capture a result this cycle
    logic                   insert;  // shift in a new entry
    logic                   remove;  // pop the head
    logic [STATUS_BITS-1:0] status;
  } spq_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } spq_stat_t;

endpackage

// ===== rtl/spq_ctrl.sv =====
// Controller for the sorted priority queue: handshake state machine that
// decodes each accepted word into a datapath command. Depends on spq_pkg.
module spq_ctrl
  import spq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  logic      in_action,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  spq_stat_t stat,
  output spq_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_HOLD = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  // A new word can enter whenever the result register is empty or drains now.
  assign in_tready  = (state_r == ST_IDLE) || out_tready;
  assign out_tvalid = (state_r == ST_HOLD);
  assign accept     = in_tvalid && in_tready;

  always_comb begin
    cmd        = '0;
    cmd.load   = accept;
    cmd.status = STATUS_DONE;
    if (in_action == ACT_INSERT) begin
      if (stat.full) begin
        cmd.status = STATUS_FULL;
      end else begin
        cmd.insert = accept;
      end
    end else begin
      if (stat.empty) begin
        cmd.status = STATUS_EMPTY;
      end else begin
        cmd.remove = accept;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_tready && !accept) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/spq_dp.sv =====
// Datapath for the sorted priority queue: a row of entry cells with parallel
// priority compare, the entry count and the result register. Depends on spq_pkg.
module spq_dp
  import spq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  spq_cmd_t                cmd,
  input  logic [PAYLOAD_BITS-1:0] in_payload,
  input  logic [PRIO_BITS-1:0]    in_prio,
  output spq_stat_t               stat,
  output logic [PAYLOAD_BITS-1:0] res_payload,
  output logic [PRIO_BITS-1:0]    res_prio,
  output logic [STATUS_BITS-1:0]  res_status,
  output logic [CNT_BITS-1:0]     res_occ
);

  logic [PAYLOAD_BITS-1:0] pay_r  [CAPACITY];
  logic [PRIO_BITS-1:0]    prio_r [CAPACITY];
  logic [CNT_BITS-1:0]     count_r, count_nxt;
  logic [CAPACITY-1:0]     mark;

  logic [PAYLOAD_BITS-1:0] res_payload_r;
  logic [PRIO_BITS-1:0]    res_prio_r;
  logic [STATUS_BITS-1:0]  res_status_r;
  logic [CNT_BITS-1:0]     res_occ_r;

  assign stat.full  = (count_r == CNT_BITS'(CAPACITY));
  assign stat.empty = (count_r == '0);

  // A marked cell lies at or behind the insertion point. Held entries are
  // sorted, so the marks form one run that starts at the insertion point.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (CNT_BITS'(i) < count_r) begin
        mark[i] = (prio_r[i] < in_prio);
      end else begin
        mark[i] = (CNT_BITS'(i) == count_r);
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic from_prev;
    if (g == 0) begin : g_head
      assign from_prev = 1'b0;
    end else begin : g_body
      assign from_prev = mark[g-1];
    end

    always_ff @(posedge clk) begin
      if (cmd.insert && mark[g]) begin
        if (from_prev) begin
          if (g > 0) begin
            pay_r[g]  <= pay_r[(g > 0) ? g - 1 : 0];
            prio_r[g] <= prio_r[(g > 0) ? g - 1 : 0];
          end
        end else begin
          pay_r[g]  <= in_payload;
          prio_r[g] <= in_prio;
        end
      end else if (cmd.remove && (g < CAPACITY - 1)) begin
        pay_r[g]  <= pay_r[(g < CAPACITY - 1) ? g + 1 : g];
        prio_r[g] <= prio_r[(g < CAPACITY - 1) ? g + 1 : g];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.insert) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.remove) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_status_r  <= cmd.status;
      res_occ_r     <= count_nxt;
      res_payload_r <= cmd.remove ? pay_r[0]  : '0;
      res_prio_r    <= cmd.remove ? prio_r[0] : '0;
    end
  end

  assign res_payload = res_payload_r;
  assign res_prio    = res_prio_r;
  assign res_status  = res_status_r;
  assign res_occ     = res_occ_r;

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: joins the controller and the
// datapath to the stream ports. Depends on spq_pkg, spq_ctrl and spq_dp.
//
//  Channel  Direction  Data                                 User
//  in_      slave      payload[31:0], prio[39:32]           action
//  out_     master     payload[31:0], prio[39:32],          status
//                      occupancy[44:40], zero pad to 48
//
// Each word is executed in the cycle it is accepted and its result is shown
// on the next cycle, so the queue sustains one word per cycle while results drain.
// The whole queue row shifts in that cycle; the parallel priority compare
// over all cells sets the clock period.
// Reset empties the queue; entry contents are not cleared.
// A stalled result holds; a new word is taken only as that result drains.
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,   // payload, prio
  input  logic                     in_tuser,   // action
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata,  // payload, prio, occupancy, pad
  output logic [STATUS_BITS-1:0]   out_tuser   // status
);

  spq_cmd_t                cmd;
  spq_stat_t               stat;
  logic [PAYLOAD_BITS-1:0] res_payload;
  logic [PRIO_BITS-1:0]    res_prio;
  logic [STATUS_BITS-1:0]  res_status;
  logic [CNT_BITS-1:0]     res_occ;

  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_action  (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  spq_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_payload  (in_tdata[PAYLOAD_BITS-1:0]),
    .in_prio     (in_tdata[PAYLOAD_BITS +: PRIO_BITS]),
    .stat        (stat),
    .res_payload (res_payload),
    .res_prio    (res_prio),
    .res_status  (res_status),
    .res_occ     (res_occ)
  );

  assign out_tdata = OUT_DATA_BITS'({res_occ, res_prio, res_payload});
  assign out_tuser = res_status;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res_occ <= CNT_BITS'(CAPACITY)))
    else $error("occupancy beyond capacity");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_status == STATUS_FULL) |-> (res_occ == CNT_BITS'(CAPACITY)))
    else $error("full rejection with queue not full");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_status == STATUS_EMPTY) |-> (res_occ == '0))
    else $error("empty status with entries held");

  a_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_status != STATUS_DONE) |-> (res_payload == '0 && res_prio == '0))
    else $error("failed request returned an entry");

endmodule
